// ===== rtl/core/cle_pkg.sv =====
// Shared constants and codes for the cursor list engine.
package cle_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int POS_W        = 8;
   localparam int REQ_W        = 3;
   localparam int STAT_W       = 3;
   localparam int FIELD_W      = 5;
   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_TDATA_W  = 48;

   typedef enum logic [REQ_W-1:0] {
      REQ_FRONT      = 3'd0,
      REQ_END        = 3'd1,
      REQ_POSITION   = 3'd2,
      REQ_SORTED     = 3'd3,
      REQ_DELETE_ONE = 3'd4,
      REQ_DELETE_ALL = 3'd5,
      REQ_DUMP       = 3'd6,
      REQ_CLEAR      = 3'd7
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE      = 3'd0,
      ST_FULL      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_DUMP      = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

endpackage

// ===== rtl/core/cle_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cursor_list_engine.sv =====
// Cursor list engine top level: request sequencer over the value and link memories.
// Clears and empty dumps go straight to the response; inserts first take a slot off the free chain;
// end, position and sorted inserts, deletes and dumps then walk the list slot by slot.
// Requests are taken one at a time; a dump gives one result per list slot, each waiting for the output.
// Reset (synchronous): empty list, free chain 0..CAPACITY-1; unwritten links read chained.
module cursor_list_engine #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cle_pkg::REQ_TDATA_W-1:0] req_tdata,  // value, position
   input  logic [cle_pkg::REQ_W-1:0]       req_tuser,  // req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cle_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // data, slot, removed_count, list_length
   output logic [cle_pkg::STAT_W-1:0]      rsp_tuser,  // status
   output logic                            rsp_tlast   // last
);
   import cle_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SW = $clog2(CAPACITY + 1);
   localparam logic [SW-1:0] NIL = SW'(CAPACITY);
   localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_INS, S_INS_FREE, S_FRONT, S_TAIL_SET, S_TAIL_RD, S_TAIL_CHK,
      S_POS_RD, S_POS_CHK, S_SRT_RD, S_SRT_P, S_SRT_NRD, S_SRT_N, S_AFT, S_AFT2,
      S_INS_DONE, S_DEL_RD, S_DEL_CHK, S_DEL_REL, S_DA_HRD, S_DA_HCHK, S_DA_PRD,
      S_DA_P, S_DA_NRD, S_DA_N, S_DA_REL, S_DA_END, S_DMP_RD, S_DMP_OUT, S_RESP
   } state_type;

   state_type           state_ff;
   req_kind_type        kind_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    step_ff;
   logic                srt_first_ff;
   logic [SW-1:0]       head_ff, free_ff, count_ff, removed_ff;
   logic [SW-1:0]       new_ff, prev_ff, cur_ff, nx_ff;
   logic [CAPACITY-1:0] link_valid_ff;
   logic                rd_valid_ff;
   logic [SW-1:0]       rd_slot_ff;

   status_type          res_status_ff;
   logic [VALUE_W-1:0]  res_data_ff;
   logic [SW-1:0]       res_slot_ff, res_rem_ff;
   logic                res_last_ff;

   logic                out_valid_ff, out_last_ff;
   logic [STAT_W-1:0]   out_status_ff;
   logic [VALUE_W-1:0]  out_data_ff;
   logic [FIELD_W-1:0]  out_slot_ff, out_rem_ff, out_len_ff;

   logic                rd_en, val_we, link_we;
   logic [SW-1:0]       rd_slot, link_wa, link_wd;
   logic [VALUE_W-1:0]  val_rd_raw;
   logic signed [VALUE_W-1:0] val_rd;
   logic [SW-1:0]       link_rd, next_rd;
   logic                out_free, accept;

   cle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (new_ff[IW-1:0]),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_slot[IW-1:0]),
      .rd_data (val_rd_raw)
   );

   cle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa[IW-1:0]),
      .wr_data (link_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_slot[IW-1:0]),
      .rd_data (link_rd)
   );

   assign val_rd = val_rd_raw;

   always_comb begin
      if (!rd_valid_ff) begin
         next_rd = (rd_slot_ff == LAST_SLOT) ? NIL : rd_slot_ff + 1'b1;
      end else if (link_rd < NIL) begin
         next_rd = link_rd;
      end else begin
         next_rd = NIL;
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_slot = cur_ff;
      val_we  = 1'b0;
      link_we = 1'b0;
      link_wa = new_ff;
      link_wd = NIL;
      unique case (state_ff)
         S_INS: begin
            rd_en   = 1'b1;
            rd_slot = free_ff;
         end
         S_POS_RD, S_SRT_RD, S_DA_PRD: begin
            rd_en   = 1'b1;
            rd_slot = prev_ff;
         end
         S_TAIL_RD, S_DEL_RD, S_DMP_RD: begin
            rd_en   = 1'b1;
            rd_slot = cur_ff;
         end
         S_SRT_NRD, S_DA_NRD: begin
            rd_en   = 1'b1;
            rd_slot = nx_ff;
         end
         S_DA_HRD: begin
            rd_en   = 1'b1;
            rd_slot = head_ff;
         end
         S_INS_FREE: val_we = 1'b1;
         S_TAIL_SET: begin
            link_we = 1'b1;
         end
         S_TAIL_CHK: begin
            link_we = (next_rd == NIL);
            link_wa = cur_ff;
            link_wd = new_ff;
         end
         S_FRONT: begin
            link_we = 1'b1;
            link_wd = head_ff;
         end
         S_AFT: begin
            link_we = 1'b1;
            link_wd = nx_ff;
         end
         S_AFT2: begin
            link_we = 1'b1;
            link_wa = prev_ff;
            link_wd = new_ff;
         end
         S_DEL_CHK: begin
            link_we = (val_rd == value_ff) && (prev_ff != NIL);
            link_wa = prev_ff;
            link_wd = next_rd;
         end
         S_DEL_REL: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = free_ff;
         end
         S_DA_HCHK: begin
            link_we = (val_rd == value_ff);
            link_wa = head_ff;
            link_wd = free_ff;
         end
         S_DA_N: begin
            link_we = (val_rd == value_ff);
            link_wa = prev_ff;
            link_wd = next_rd;
         end
         S_DA_REL: begin
            link_we = 1'b1;
            link_wa = nx_ff;
            link_wd = free_ff;
         end
         default: ;
      endcase
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= NIL;
         free_ff       <= '0;
         count_ff      <= '0;
         link_valid_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_valid_ff <= link_valid_ff[rd_slot[IW-1:0]];
            rd_slot_ff  <= rd_slot;
         end
         if (link_we) begin
            link_valid_ff[link_wa[IW-1:0]] <= 1'b1;
         end
         if (out_valid_ff && rsp_tready && state_ff != S_RESP) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  kind_ff    <= req_kind_type'(req_tuser);
                  value_ff   <= req_tdata[VALUE_W-1:0];
                  pos_ff     <= req_tdata[VALUE_W +: POS_W];
                  prev_ff    <= NIL;
                  cur_ff     <= head_ff;
                  removed_ff <= '0;
                  res_data_ff <= '0;
                  res_slot_ff <= NIL;
                  res_rem_ff  <= '0;
                  res_last_ff <= 1'b1;
                  unique case (req_kind_type'(req_tuser))
                     REQ_FRONT, REQ_END, REQ_POSITION, REQ_SORTED: state_ff <= S_INS;
                     REQ_DELETE_ONE: state_ff <= S_DEL_RD;
                     REQ_DELETE_ALL: state_ff <= S_DA_HRD;
                     REQ_DUMP: begin
                        if (head_ff == NIL) begin
                           res_status_ff <= ST_EMPTY;
                           state_ff      <= S_RESP;
                        end else begin
                           state_ff <= S_DMP_RD;
                        end
                     end
                     REQ_CLEAR: begin
                        link_valid_ff <= '0;
                        head_ff       <= NIL;
                        free_ff       <= '0;
                        count_ff      <= '0;
                        res_status_ff <= ST_DONE;
                        state_ff      <= S_RESP;
                     end
                  endcase
               end
            end
            S_INS: begin
               if (free_ff == NIL) begin
                  res_status_ff <= ST_FULL;
                  state_ff      <= S_RESP;
               end else begin
                  new_ff   <= free_ff;
                  state_ff <= S_INS_FREE;
               end
            end
            S_INS_FREE: begin
               free_ff      <= next_rd;
               prev_ff      <= head_ff;
               step_ff      <= POS_W'(1);
               srt_first_ff <= 1'b1;
               unique case (kind_ff)
                  REQ_END: state_ff <= S_TAIL_SET;
                  REQ_POSITION: begin
                     if (pos_ff <= POS_W'(1) || head_ff == NIL) begin
                        state_ff <= S_FRONT;
                     end else begin
                        state_ff <= S_POS_RD;
                     end
                  end
                  REQ_SORTED: state_ff <= (head_ff == NIL) ? S_FRONT : S_SRT_RD;
                  default: state_ff <= S_FRONT;
               endcase
            end
            S_FRONT: begin
               head_ff  <= new_ff;
               state_ff <= S_INS_DONE;
            end
            S_TAIL_SET: begin
               cur_ff <= head_ff;
               if (head_ff == NIL) begin
                  head_ff  <= new_ff;
                  state_ff <= S_INS_DONE;
               end else begin
                  state_ff <= S_TAIL_RD;
               end
            end
            S_TAIL_RD: state_ff <= S_TAIL_CHK;
            S_TAIL_CHK: begin
               if (next_rd == NIL) begin
                  state_ff <= S_INS_DONE;
               end else begin
                  cur_ff   <= next_rd;
                  state_ff <= S_TAIL_RD;
               end
            end
            S_POS_RD: state_ff <= S_POS_CHK;
            S_POS_CHK: begin
               if (step_ff < pos_ff - 1'b1) begin
                  prev_ff  <= next_rd;
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= (next_rd == NIL) ? S_TAIL_SET : S_POS_RD;
               end else begin
                  nx_ff    <= next_rd;
                  state_ff <= S_AFT;
               end
            end
            S_SRT_RD: state_ff <= S_SRT_P;
            S_SRT_P: begin
               srt_first_ff <= 1'b0;
               if (srt_first_ff && value_ff <= val_rd) begin
                  state_ff <= S_FRONT;
               end else begin
                  nx_ff    <= next_rd;
                  state_ff <= (next_rd == NIL) ? S_AFT : S_SRT_NRD;
               end
            end
            S_SRT_NRD: state_ff <= S_SRT_N;
            S_SRT_N: begin
               if (val_rd < value_ff) begin
                  prev_ff  <= nx_ff;
                  state_ff <= S_SRT_P;
               end else begin
                  state_ff <= S_AFT;
               end
            end
            S_AFT:  state_ff <= S_AFT2;
            S_AFT2: state_ff <= S_INS_DONE;
            S_INS_DONE: begin
               count_ff      <= count_ff + 1'b1;
               res_status_ff <= ST_DONE;
               res_data_ff   <= value_ff;
               res_slot_ff   <= new_ff;
               state_ff      <= S_RESP;
            end
            S_DEL_RD: begin
               if (cur_ff == NIL) begin
                  res_status_ff <= ST_NOT_FOUND;
                  state_ff      <= S_RESP;
               end else begin
                  state_ff <= S_DEL_CHK;
               end
            end
            S_DEL_CHK: begin
               if (val_rd == value_ff) begin
                  if (prev_ff == NIL) begin
                     head_ff <= next_rd;
                  end
                  state_ff <= S_DEL_REL;
               end else begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= next_rd;
                  state_ff <= S_DEL_RD;
               end
            end
            S_DEL_REL: begin
               free_ff       <= cur_ff;
               count_ff      <= count_ff - 1'b1;
               res_status_ff <= ST_DONE;
               res_slot_ff   <= cur_ff;
               res_rem_ff    <= SW'(1);
               state_ff      <= S_RESP;
            end
            S_DA_HRD: state_ff <= (head_ff == NIL) ? S_DA_END : S_DA_HCHK;
            S_DA_HCHK: begin
               if (val_rd == value_ff) begin
                  head_ff    <= next_rd;
                  free_ff    <= head_ff;
                  count_ff   <= count_ff - 1'b1;
                  removed_ff <= removed_ff + 1'b1;
                  state_ff   <= S_DA_HRD;
               end else begin
                  prev_ff  <= head_ff;
                  state_ff <= S_DA_P;
               end
            end
            S_DA_PRD: state_ff <= S_DA_P;
            S_DA_P: begin
               nx_ff    <= next_rd;
               state_ff <= (next_rd == NIL) ? S_DA_END : S_DA_NRD;
            end
            S_DA_NRD: state_ff <= S_DA_N;
            S_DA_N: begin
               if (val_rd == value_ff) begin
                  state_ff <= S_DA_REL;
               end else begin
                  prev_ff  <= nx_ff;
                  state_ff <= S_DA_P;
               end
            end
            S_DA_REL: begin
               free_ff    <= nx_ff;
               count_ff   <= count_ff - 1'b1;
               removed_ff <= removed_ff + 1'b1;
               state_ff   <= S_DA_PRD;
            end
            S_DA_END: begin
               res_status_ff <= (removed_ff != '0) ? ST_DONE : ST_NOT_FOUND;
               res_rem_ff    <= removed_ff;
               state_ff      <= S_RESP;
            end
            S_DMP_RD: state_ff <= S_DMP_OUT;
            S_DMP_OUT: begin
               res_status_ff <= ST_DUMP;
               res_data_ff   <= val_rd;
               res_slot_ff   <= cur_ff;
               res_last_ff   <= (next_rd == NIL);
               cur_ff        <= next_rd;
               state_ff      <= S_RESP;
            end
            S_RESP: begin
               if (out_free) begin
                  out_valid_ff  <= 1'b1;
                  out_status_ff <= res_status_ff;
                  out_data_ff   <= res_data_ff;
                  out_slot_ff   <= FIELD_W'(res_slot_ff);
                  out_rem_ff    <= FIELD_W'(res_rem_ff);
                  out_len_ff    <= FIELD_W'(count_ff);
                  out_last_ff   <= res_last_ff;
                  state_ff      <= res_last_ff ? S_IDLE : S_DMP_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_len_ff, out_rem_ff, out_slot_ff, out_data_ff};

endmodule

// ===== rtl/core/cle_checker.sv =====
// Port-level checker for the cursor list engine, bound to the top level.
module cle_checker #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cle_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [cle_pkg::STAT_W-1:0]      rsp_tuser,
   input logic                            rsp_tlast
);
   import cle_pkg::*;

   localparam logic [FIELD_W-1:0] NONE = FIELD_W'(CAPACITY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DUMP |-> rsp_tlast)
      else $error("non-dump result without last");

   a_full_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL || rsp_tuser == ST_EMPTY ||
                     rsp_tuser == ST_NOT_FOUND) |-> rsp_tdata[36:32] == NONE)
      else $error("slot given on a result that uses none");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 31) || (rsp_tdata[46:42] <= NONE))
      else $error("list length beyond capacity");

endmodule

bind cursor_list_engine cle_checker #(.CAPACITY(CAPACITY)) u_cle_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
